@@ rtl/lcpi_pkg.sv @@
// ----------------------------------------------------------------------------
// lcpi_pkg
// Shared types and constants for the layered color palette indexer.
// ----------------------------------------------------------------------------
package lcpi_pkg;

  localparam int COLOR_W      = 32;
  localparam int LAYER_INPUTS = 4;
  localparam int LAYERS_W     = 3;
  localparam int LCNT_W       = 4;
  localparam int IDX_OUT_W    = 8;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 8;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] CFG_THREE_BYTE_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LAYERS_IN_USE   = CFG_IDX_W'(1);

  // controller -> datapath
  typedef struct packed {
    logic capture;  // take the input transfer, build key
    logic search;   // walk the table one entry per cycle
    logic commit;   // produce result, append on miss
  } lcpi_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;        // key matched the entry read last cycle
    logic exhausted;  // all entries read, nothing in flight
    logic out_free;   // output register can take a result
  } lcpi_status_t;

endpackage

@@ rtl/lcpi_ctrl.sv @@
// ----------------------------------------------------------------------------
// lcpi_ctrl
// Sequencer: capture a pixel, search the palette table, commit the result.
// ----------------------------------------------------------------------------
module lcpi_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lcpi_pkg::lcpi_status_t status_i,
  output lcpi_pkg::lcpi_cmd_t    cmd_o
);
  import lcpi_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RESULT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd_o         = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_o.capture = 1'b1;
          state_nxt     = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (status_i.hit || status_i.exhausted) begin
          state_nxt = ST_RESULT;
        end else begin
          cmd_o.search = 1'b1;
        end
      end
      ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.commit |-> status_i.out_free)
    else $error("commit without room in output register");

  a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd_o))
    else $error("more than one command at once");

  a_capture_then_search: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.capture |=> (state_r == ST_SEARCH))
    else $error("capture not followed by search");

endmodule

@@ rtl/lcpi_dp.sv @@
// ----------------------------------------------------------------------------
// lcpi_dp
// Datapath: config registers, key build, tuple table, search pointer,
// entry count and output register.
// ----------------------------------------------------------------------------
module lcpi_dp #(
  parameter int MAX_LAYERS   = 4,
  parameter int PALETTE_SIZE = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lcpi_pkg::lcpi_cmd_t               cmd_i,
  output lcpi_pkg::lcpi_status_t            status_o,
  input  logic                              cfg_valid,
  input  logic [lcpi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lcpi_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_first_pixel,
  input  logic [lcpi_pkg::COLOR_W-1:0]      in_color_layer0,
  input  logic [lcpi_pkg::COLOR_W-1:0]      in_color_layer1,
  input  logic [lcpi_pkg::COLOR_W-1:0]      in_color_layer2,
  input  logic [lcpi_pkg::COLOR_W-1:0]      in_color_layer3,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lcpi_pkg::IDX_OUT_W-1:0]    out_palette_index,
  output logic                              out_is_new,
  output logic                              out_table_full
);
  import lcpi_pkg::*;

  localparam int KEY_W = MAX_LAYERS * COLOR_W;
  localparam int AW    = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
  localparam int CW    = $clog2(PALETTE_SIZE + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(PALETTE_SIZE);

  // configuration
  logic                three_byte_r;
  logic [LAYERS_W-1:0] layers_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      three_byte_r <= 1'b0;
      layers_r     <= LAYERS_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_THREE_BYTE_MODE: three_byte_r <= cfg_wdata[0];
        CFG_LAYERS_IN_USE:   layers_r     <= cfg_wdata[LAYERS_W-1:0];
        default: ;
      endcase
    end
  end

  // key build: unused layers read as zero, alpha forced in three-byte mode
  logic [COLOR_W-1:0] layer_in  [LAYER_INPUTS];
  logic [COLOR_W-1:0] layer_raw [MAX_LAYERS];
  logic [LCNT_W-1:0]  n_act;
  logic [KEY_W-1:0]   key_nxt;

  assign layer_in[0] = in_color_layer0;
  assign layer_in[1] = in_color_layer1;
  assign layer_in[2] = in_color_layer2;
  assign layer_in[3] = in_color_layer3;

  for (genvar g = 0; g < MAX_LAYERS; g++) begin : g_raw
    if (g < LAYER_INPUTS) begin : g_port
      assign layer_raw[g] = layer_in[g];
    end else begin : g_none
      assign layer_raw[g] = '0;
    end
  end

  always_comb begin
    logic [COLOR_W-1:0] w;
    if (layers_r == '0) begin
      n_act = LCNT_W'(1);
    end else if (LCNT_W'(layers_r) > LCNT_W'(MAX_LAYERS)) begin
      n_act = LCNT_W'(MAX_LAYERS);
    end else begin
      n_act = LCNT_W'(layers_r);
    end
    key_nxt = '0;
    for (int k = 0; k < MAX_LAYERS; k++) begin
      w = '0;
      if (LCNT_W'(k) < n_act) begin
        w = layer_raw[k];
        if (three_byte_r) begin
          w[31:24] = ALPHA_OPAQUE;
        end
      end
      key_nxt[k*COLOR_W +: COLOR_W] = w;
    end
  end

  // tuple table and search
  logic [KEY_W-1:0] mem [PALETTE_SIZE];
  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] rdata_r;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    idx_r;
  logic [AW-1:0]    rd_idx_r;
  logic             rd_vld_r;
  logic             hit_r;
  logic [AW-1:0]    hit_idx_r;
  logic             match;
  logic             issue;
  logic             append;

  assign match  = rd_vld_r && (rdata_r == key_r);
  assign issue  = cmd_i.search && !match && (idx_r < count_r);
  assign append = cmd_i.commit && !hit_r && (count_r != FULL_CNT);

  always_ff @(posedge clk) begin
    if (issue) begin
      rdata_r  <= mem[idx_r[AW-1:0]];
      rd_idx_r <= idx_r[AW-1:0];
    end
    if (append) begin
      mem[count_r[AW-1:0]] <= key_r;
    end
    if (cmd_i.capture) begin
      key_r <= key_nxt;
    end
    // match is only seen in the compare cycle after a read
    if (match) begin
      hit_idx_r <= rd_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
      hit_r    <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        idx_r    <= '0;
        rd_vld_r <= 1'b0;
        hit_r    <= 1'b0;
        if (in_first_pixel) begin
          count_r <= '0;
        end
      end else begin
        rd_vld_r <= issue;
        if (issue) begin
          idx_r <= idx_r + CW'(1);
        end
        if (match) begin
          hit_r <= 1'b1;
        end
        if (append) begin
          count_r <= count_r + CW'(1);
        end
      end
    end
  end

  // output register
  logic                 out_valid_r;
  logic [IDX_OUT_W-1:0] out_index_r;
  logic                 out_is_new_r;
  logic                 out_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.commit) begin
      if (hit_r) begin
        out_index_r  <= IDX_OUT_W'(hit_idx_r);
        out_is_new_r <= 1'b0;
        out_full_r   <= 1'b0;
      end else if (count_r == FULL_CNT) begin
        out_index_r  <= '0;
        out_is_new_r <= 1'b0;
        out_full_r   <= 1'b1;
      end else begin
        out_index_r  <= IDX_OUT_W'(count_r);
        out_is_new_r <= 1'b1;
        out_full_r   <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_palette_index = out_index_r;
  assign out_is_new        = out_is_new_r;
  assign out_table_full    = out_full_r;

  assign status_o.hit       = match;
  assign status_o.exhausted = (idx_r == count_r) && !rd_vld_r;
  assign status_o.out_free  = !out_valid_r || !out_stall;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count beyond table size");

  a_new_xor_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_is_new_r && out_full_r))
    else $error("result both new and full");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    append |=> (count_r == $past(count_r) + CW'(1)))
    else $error("append did not advance entry count");

endmodule

@@ rtl/layered_color_palette_indexer.sv @@
// ----------------------------------------------------------------------------
// layered_color_palette_indexer
// Assigns palette indices to multi-layer color tuples in order of first
// appearance.
// ----------------------------------------------------------------------------
// One pixel is taken at a time. A transfer is captured, then the tuple
// table is searched linearly from entry 0, one entry per cycle through the
// table's single read port with registered read data, and then the result
// is committed. A tuple found at entry e ends the search there; a new
// tuple (or a full table) is known only after every stored entry has been
// read, so the search loop over stored entries sets the rate. The input is
// held off with in_stall while a pixel is in work; a finished result waits
// in the output register while the next pixel is taken. Configuration
// writes are taken every cycle (cfg_ready is high).
// in_first_pixel empties the table before that pixel is searched.
// ----------------------------------------------------------------------------
module layered_color_palette_indexer #(
  parameter int MAX_LAYERS   = 4,
  parameter int PALETTE_SIZE = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_first_pixel,
  input  logic [lcpi_pkg::COLOR_W-1:0]      in_color_layer0,
  input  logic [lcpi_pkg::COLOR_W-1:0]      in_color_layer1,
  input  logic [lcpi_pkg::COLOR_W-1:0]      in_color_layer2,
  input  logic [lcpi_pkg::COLOR_W-1:0]      in_color_layer3,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lcpi_pkg::IDX_OUT_W-1:0]    out_palette_index,
  output logic                              out_is_new,
  output logic                              out_table_full,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lcpi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lcpi_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import lcpi_pkg::*;

  lcpi_cmd_t    cmd;
  lcpi_status_t status;

  assign cfg_ready = 1'b1;

  lcpi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status_i (status),
    .cmd_o    (cmd)
  );

  lcpi_dp #(
    .MAX_LAYERS   (MAX_LAYERS),
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_valid         (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_first_pixel    (in_first_pixel),
    .in_color_layer0   (in_color_layer0),
    .in_color_layer1   (in_color_layer1),
    .in_color_layer2   (in_color_layer2),
    .in_color_layer3   (in_color_layer3),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_palette_index (out_palette_index),
    .out_is_new        (out_is_new),
    .out_table_full    (out_table_full)
  );

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the layered color palette indexer: a directed
// table of pixels and register settings, then randomized phases of pixel
// streams with repeats, table clears and a table-overflow run. Each result
// is checked against an in-bench palette tracker or a hand-written result.
// ----------------------------------------------------------------------------
module tb;
  import lcpi_pkg::*;

  localparam int MAX_LAYERS     = 4;
  localparam int PALETTE_SIZE   = 256;
  localparam int LONG_HOLD      = 120;
  localparam int TAIL_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int N_DIRECTED     = 20;
  localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_REG = CFG_LAYERS_IN_USE + 1'b1;

  typedef logic [MAX_LAYERS-1:0][COLOR_W-1:0] tuple_t;

  typedef struct packed {
    logic   first;
    tuple_t color;
  } pixel_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] index;
    logic                 is_new;
    logic                 full;
  } palette_result_t;

  typedef struct packed {
    logic            set_cfg;
    logic [7:0]      mode_wr;
    logic [7:0]      layers_wr;
    logic            first;
    logic [31:0]     c0;
    logic [31:0]     c1;
    logic [31:0]     c2;
    logic [31:0]     c3;
    logic            typed;
    palette_result_t want;
  } stim_row_t;

  // set_cfg, mode, layers, first, layer0..3, typed, {index, is_new, full}
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{1'b1, 8'h00, 8'h01, 1'b1, 32'h00000000, 32'h00000000, 32'h00000000,
      32'h00000000, 1'b1, '{8'd0, 1'b1, 1'b0}},
    '{1'b0, 8'h00, 8'h00, 1'b0, 32'h00000000, 32'h00000000, 32'h00000000,
      32'h00000000, 1'b1, '{8'd0, 1'b0, 1'b0}},
    '{1'b0, 8'h00, 8'h00, 1'b0, 32'hFFFFFFFF, 32'h00000000, 32'h00000000,
      32'h00000000, 1'b1, '{8'd1, 1'b1, 1'b0}},
    '{1'b0, 8'h00, 8'h00, 1'b0, 32'h00000000, 32'hFFFFFFFF, 32'hFFFFFFFF,
      32'hFFFFFFFF, 1'b1, '{8'd0, 1'b0, 1'b0}},
    '{1'b0, 8'h00, 8'h00, 1'b0, 32'hFFFFFFFF, 32'h00000000, 32'h00000000,
      32'h00000000, 1'b1, '{8'd1, 1'b0, 1'b0}},
    '{1'b1, 8'hFF, 8'h01, 1'b0, 32'h00FFFFFF, 32'h00000000, 32'h00000000,
      32'h00000000, 1'b1, '{8'd1, 1'b0, 1'b0}},
    '{1'b0, 8'h00, 8'h00, 1'b0, 32'h12000000, 32'h00000000, 32'h00000000,
      32'h00000000, 1'b1, '{8'd2, 1'b1, 1'b0}},
    '{1'b0, 8'h00, 8'h00, 1'b0, 32'hFFFFFFFF, 32'h00000000, 32'h00000000,
      32'h00000000, 1'b1, '{8'd1, 1'b0, 1'b0}},
    '{1'b1, 8'h00, 8'h02, 1'b0, 32'h00000000, 32'h00000000, 32'h00000000,
      32'h00000000, 1'b0, '{8'd0, 1'b0, 1'b0}},
    '{1'b0, 8'h00, 8'h00, 1'b0, 32'hFFFFFFFF, 32'h00000001, 32'h00000000,
      32'h00000000, 1'b1, '{8'd3, 1'b1, 1'b0}},
    '{1'b1, 8'hFE, 8'h00, 1'b0, 32'hFFFFFFFF, 32'h00000005, 32'h00000000,
      32'h00000000, 1'b0, '{8'd0, 1'b0, 1'b0}},
    '{1'b1, 8'h00, 8'h07, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
      32'hFFFFFFFF, 1'b1, '{8'd4, 1'b1, 1'b0}},
    '{1'b1, 8'h00, 8'h04, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
      32'hFFFFFFFF, 1'b1, '{8'd4, 1'b0, 1'b0}},
    '{1'b1, 8'h00, 8'hFF, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
      32'hFFFFFFFF, 1'b0, '{8'd0, 1'b0, 1'b0}},
    '{1'b1, 8'h00, 8'h03, 1'b0, 32'hA5A5A5A5, 32'h5A5A5A5A, 32'h0F0F0F0F,
      32'hF0F0F0F0, 1'b1, '{8'd5, 1'b1, 1'b0}},
    '{1'b1, 8'h00, 8'hF9, 1'b1, 32'h80000001, 32'h00000000, 32'h00000000,
      32'h00000000, 1'b1, '{8'd0, 1'b1, 1'b0}},
    '{1'b1, 8'h01, 8'h04, 1'b0, 32'h00000000, 32'h00000000, 32'h00000000,
      32'h00000000, 1'b1, '{8'd1, 1'b1, 1'b0}},
    '{1'b0, 8'h00, 8'h00, 1'b0, 32'h7F000000, 32'h01000000, 32'hFE000000,
      32'h80000000, 1'b1, '{8'd1, 1'b0, 1'b0}},
    '{1'b1, 8'h00, 8'h04, 1'b0, 32'h00000000, 32'h00000000, 32'h00000000,
      32'h00000000, 1'b1, '{8'd2, 1'b1, 1'b0}},
    '{1'b0, 8'h00, 8'h00, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
      32'hFFFFFFFF, 1'b1, '{8'd0, 1'b1, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_stall, in_first_pixel;
  logic [COLOR_W-1:0] in_color_layer0, in_color_layer1, in_color_layer2, in_color_layer3;
  logic out_valid, out_stall, out_is_new, out_table_full;
  logic [IDX_OUT_W-1:0] out_palette_index;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // tracker state
  tuple_t          palette_tbl [PALETTE_SIZE];
  int              used_entries = 0;
  logic            alpha_forced = 1'b0;
  logic [2:0]      layer_sel    = 3'd1;
  palette_result_t expected_results [$];
  int              mismatches = 0;

  // directed rows with a hand-written result
  logic            row_typed = 1'b0;
  palette_result_t row_want  = '0;

  bit quiet_tail    = 1'b0;
  bit long_hold_req = 1'b0;

  always #1 clk = ~clk;

  layered_color_palette_indexer #(
    .MAX_LAYERS  (MAX_LAYERS),
    .PALETTE_SIZE(PALETTE_SIZE)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_first_pixel   (in_first_pixel),
    .in_color_layer0  (in_color_layer0),
    .in_color_layer1  (in_color_layer1),
    .in_color_layer2  (in_color_layer2),
    .in_color_layer3  (in_color_layer3),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_palette_index(out_palette_index),
    .out_is_new       (out_is_new),
    .out_table_full   (out_table_full),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  function automatic int active_count();
    int n;
    n = int'(layer_sel);
    if (n < 1) n = 1;
    if (n > MAX_LAYERS) n = MAX_LAYERS;
    return n;
  endfunction

  // Look up the tuple, append on miss; unused layers are stored as zero.
  function automatic palette_result_t index_pixel(pixel_t px);
    tuple_t          key;
    int              n;
    palette_result_t r;
    n = active_count();
    if (px.first) used_entries = 0;
    for (int k = 0; k < MAX_LAYERS; k++) begin
      key[k] = (k < n) ? px.color[k] : '0;
      if (k < n && alpha_forced) key[k][31:24] = ALPHA_OPAQUE;
    end
    for (int e = 0; e < used_entries; e++) begin
      if (palette_tbl[e] == key) begin
        r = '{index: e[7:0], is_new: 1'b0, full: 1'b0};
        return r;
      end
    end
    if (used_entries >= PALETTE_SIZE) begin
      r = '{index: 8'd0, is_new: 1'b0, full: 1'b1};
      return r;
    end
    palette_tbl[used_entries] = key;
    r = '{index: used_entries[7:0], is_new: 1'b1, full: 1'b0};
    used_entries++;
    return r;
  endfunction

  task automatic report_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    pixel_t          seen_px;
    palette_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got index %0d", $time,
                   out_palette_index);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          report_field("palette_index", want.index, out_palette_index);
          report_field("is_new", 8'(want.is_new), 8'(out_is_new));
          report_field("table_full", 8'(want.full), 8'(out_table_full));
        end
      end
      if (in_valid && !in_stall) begin
        seen_px.first = in_first_pixel;
        seen_px.color = {in_color_layer3, in_color_layer2, in_color_layer1, in_color_layer0};
        want = index_pixel(seen_px);
        expected_results.push_back(row_typed ? row_want : want);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_THREE_BYTE_MODE: alpha_forced = cfg_wdata[0];
          CFG_LAYERS_IN_USE:   layer_sel = cfg_wdata[2:0];
          default: ;
        endcase
      end
    end
  end

  // Result-side pacing: random stall bursts, one long hold-off on request.
  initial begin : result_pacing
    int left;
    bit hold;
    left = 0;
    hold = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        if (long_hold_req) begin
          hold = 1'b1;
          left = LONG_HOLD;
          long_hold_req = 1'b0;
        end else if (quiet_tail) begin
          hold = 1'b0;
          left = 1;
        end else begin
          hold = ($urandom_range(0, 2) == 0);
          left = hold ? $urandom_range(1, 11) : $urandom_range(1, 24);
        end
      end
      out_stall <= hold;
      left--;
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("[layered_color_palette_indexer] ERROR");
    $finish;
  end

  task automatic send_pixel(pixel_t px, logic typed, palette_result_t want);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 11)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_first_pixel  <= px.first;
    in_color_layer0 <= px.color[0];
    in_color_layer1 <= px.color[1];
    in_color_layer2 <= px.color[2];
    in_color_layer3 <= px.color[3];
    row_typed       <= typed;
    row_want        <= want;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // Stop offering pixels and wait for every pending result.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Pixel stream mixing fresh tuples with repeats of earlier ones; repeats
  // get new garbage in ignored layers and, in three-byte mode, in alpha.
  task automatic run_phase(int n_items, int fresh_pct, bit clear_first, bit mid_clears);
    pixel_t seen [$];
    pixel_t px;
    for (int i = 0; i < n_items; i++) begin
      if (seen.size() == 0 || $urandom_range(0, 99) < fresh_pct) begin
        for (int k = 0; k < MAX_LAYERS; k++) px.color[k] = $urandom;
      end else begin
        px = seen[$urandom_range(0, seen.size() - 1)];
        for (int k = 0; k < MAX_LAYERS; k++) begin
          if (k >= active_count()) px.color[k] = $urandom;
          if (alpha_forced && $urandom_range(0, 1) == 1) px.color[k][31:24] = 8'($urandom);
        end
      end
      px.first = (i == 0) ? clear_first : (mid_clears && $urandom_range(0, 39) == 0);
      seen.push_back(px);
      send_pixel(px, 1'b0, '0);
    end
  endtask

  initial begin : main_seq
    pixel_t    px;
    stim_row_t row;
    bit        fill;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_first_pixel  = 1'b0;
    in_color_layer0 = '0;
    in_color_layer1 = '0;
    in_color_layer2 = '0;
    in_color_layer3 = '0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.set_cfg) begin
        drain();
        write_reg(CFG_THREE_BYTE_MODE, row.mode_wr);
        write_reg(CFG_LAYERS_IN_USE, row.layers_wr);
      end
      px.first = row.first;
      px.color = {row.c3, row.c2, row.c1, row.c0};
      send_pixel(px, row.typed, row.want);
    end

    // phase 2 overflows the table; phase 0 gets the long result hold-off
    for (int p = 0; p < 9; p++) begin
      fill = (p == 2);
      drain();
      write_reg(CFG_THREE_BYTE_MODE, 8'($urandom));
      write_reg(CFG_LAYERS_IN_USE, 8'($urandom));
      if (p == 0 || $urandom_range(0, 1) == 1)
        write_reg(FIRST_SPARE_REG + 8'($urandom_range(0, 253)), 8'($urandom));
      if (p == 0) long_hold_req = 1'b1;
      if (p == 8) quiet_tail = 1'b1;
      run_phase(fill ? 300 : 37, fill ? 85 : 30,
                fill || p == 3 || $urandom_range(0, 3) != 0, !fill);
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("[layered_color_palette_indexer] OK");
    else
      $display("[layered_color_palette_indexer] ERROR");
    $finish;
  end

endmodule

@@ layered_color_palette_indexer.f @@
rtl/lcpi_pkg.sv
rtl/lcpi_ctrl.sv
rtl/lcpi_dp.sv
rtl/layered_color_palette_indexer.sv
tb/sv/tb.sv
